### sv/xsg_pkg.sv
// Shared types, codes and constants of the seeded xoshiro256++ generator.
`timescale 1ns / 1ps

package xsg_pkg;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_BEGIN   = 3'd0;
  localparam cmd_t CMD_BYTE    = 3'd1;
  localparam cmd_t CMD_FINISH  = 3'd2;
  localparam cmd_t CMD_RAW     = 3'd3;
  localparam cmd_t CMD_UNIFORM = 3'd4;
  localparam cmd_t CMD_BOUNDED = 3'd5;

  // 256-bit FNV offset basis, word k holds bits 64k+63..64k
  localparam logic [63:0] BASIS_W0 = 64'h1023b4c8caee0535;
  localparam logic [63:0] BASIS_W1 = 64'hc8b1536847b6bbb3;
  localparam logic [63:0] BASIS_W2 = 64'h2d98c384c4e576cc;
  localparam logic [63:0] BASIS_W3 = 64'hdd268dbcaac55036;

  // FNV prime = 2^168 + 0x163; 168 = 2 words + 40 bits
  localparam logic [8:0] PRIME_LOW       = 9'h163;
  localparam int         PRIME_BIT_SHIFT = 40;

  localparam int UNIFORM_SHIFT = 12;

  typedef struct packed {
    logic       load_in;      // capture the accepted item
    logic       clear_result; // result value and status to zero
    logic       load_basis;   // hash back to the offset basis
    logic       mul_step;     // one word of the hash multiply
    logic [1:0] mul_idx;      // which word of the multiply
    logic       shift_len;    // drop the absorbed length byte
    logic       load_gen;     // copy hash into generator words
    logic       gen_step;     // one xoshiro256++ step
    logic       load_mask;    // build the rejection mask
    logic       set_result;   // take the draw into the result
    logic       set_zero_rng; // flag range zero
    logic       load_out;     // move result into the output register
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic len_zero;
    logic len_next_zero;
    logic range_zero;
    logic reject;
  } sts_t;

endpackage

### sv/xsg_req_if.sv
// Command channel of the seeded generator.
`timescale 1ns / 1ps

interface xsg_req_if;
  logic                valid;
  logic                ready;
  logic [2:0]          command;
  logic [7:0]          seed_byte;
  logic [31:0]         seed_length;
  logic [63:0]         draw_range;

  modport source (output valid, command, seed_byte, seed_length, draw_range, input ready);
  modport sink   (input valid, command, seed_byte, seed_length, draw_range, output ready);
endinterface

### sv/xsg_rsp_if.sv
// Result channel of the seeded generator.
`timescale 1ns / 1ps

interface xsg_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

### sv/xoshiro256pp_seeded_generator_unit.sv
// Top level of the seeded xoshiro256++ generator.
//
// req carries one command item (begin seed, seed byte, finish seed, raw,
// uniform or bounded draw); rsp returns exactly one item per command:
// value (64 bits) and status (1 = bounded draw asked with range zero).
// Items are taken one at a time; req.ready is high while the controller
// is idle, also while an earlier result still sits in the output register.
// Work per command after acceptance, before rsp.valid:
//   raw / uniform draw          one generator step, then the result
//   bounded draw                one generator step and one compare per try,
//                               repeated while the draw is rejected
//   bounded draw, range zero    result set at once, no draw
//   seed byte                   hash multiply, one 64-bit word a cycle
//   begin seed                  hash to the offset basis, then one hash multiply per absorbed length byte (0 to 4)
//   finish seed                 four warm-up steps, one a cycle
// The next item can be taken the cycle after the result is loaded.
// Reset puts the hash at the FNV offset basis, and the generator words read
// as zero until the first finish seed. When rsp stalls, one result waits in
// the output register; a further result holds the controller until it drains.
`timescale 1ns / 1ps

module xoshiro256pp_seeded_generator_unit (
  input logic         clk,
  input logic         rst,
  xsg_req_if.sink     req,
  xsg_rsp_if.source   rsp
);

  xsg_pkg::ctl_t ctl;
  xsg_pkg::sts_t sts;

  xsg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  xsg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .command     (req.command),
    .seed_byte   (req.seed_byte),
    .seed_length (req.seed_length),
    .draw_range  (req.draw_range),
    .ctl         (ctl),
    .sts         (sts),
    .value       (rsp.value),
    .status      (rsp.status)
  );

endmodule

### sv/xsg_datapath.sv
// Datapath: hash and generator words, word-serial hash multiply, draw and output registers.
`timescale 1ns / 1ps

module xsg_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          command,
  input  logic [7:0]          seed_byte,
  input  logic [31:0]         seed_length,
  input  logic [63:0]         draw_range,
  input  xsg_pkg::ctl_t       ctl,
  output xsg_pkg::sts_t       sts,
  output logic [63:0]         value,
  output logic                status
);

  xsg_pkg::cmd_t cmd;
  logic [7:0]    byte_reg;
  logic [31:0]   len;
  logic [63:0]   range_reg;
  logic [63:0]   mask;
  logic [63:0]   draw;
  logic [63:0]   res_value;
  logic          res_status;

  logic [63:0] hash [4];
  logic [63:0] gen  [4];
  logic [63:0] d1, d2, d3;   // earlier multiplicand words, for the 2^168 term
  logic [9:0]  carry;

  // hash multiply, one 64-bit word per cycle
  logic [7:0]  absorb_byte;
  logic [63:0] mul_a;
  logic [63:0] shift_term;
  logic [73:0] acc;

  always_comb begin
    absorb_byte = (cmd == xsg_pkg::CMD_BEGIN) ? len[7:0] : byte_reg;
    mul_a = hash[0];
    if (ctl.mul_idx == 2'd0) begin
      mul_a = hash[0] ^ {56'd0, absorb_byte};
    end
    shift_term = 64'd0;
    if (ctl.mul_idx[1]) begin
      shift_term = d2 << xsg_pkg::PRIME_BIT_SHIFT;
    end
    if (ctl.mul_idx == 2'd3) begin
      shift_term = shift_term | (d3 >> (64 - xsg_pkg::PRIME_BIT_SHIFT));
    end
    acc = ({10'd0, mul_a} * {65'd0, xsg_pkg::PRIME_LOW}) + {10'd0, shift_term}
        + {64'd0, (ctl.mul_idx == 2'd0) ? 10'd0 : carry};
  end

  // xoshiro256++ step
  logic [63:0] sum03, rot23, gen_out, t17;
  logic [63:0] s2a, s3a, s1n, s0n, s2n, s3n;

  always_comb begin
    sum03   = gen[0] + gen[3];
    rot23   = {sum03[40:0], sum03[63:41]};
    gen_out = rot23 + gen[0];
    t17     = gen[1] << 17;
    s2a     = gen[2] ^ gen[0];
    s3a     = gen[3] ^ gen[1];
    s1n     = gen[1] ^ s2a;
    s0n     = gen[0] ^ s3a;
    s2n     = s2a ^ t17;
    s3n     = {s3a[18:0], s3a[63:19]};
  end

  // mask: range - 1 with every bit below its top bit set
  logic [63:0] m0, m1, m2, m3, m4, m5, m6;
  always_comb begin
    m0 = range_reg - 64'd1;
    m1 = m0 | (m0 >> 1);
    m2 = m1 | (m1 >> 2);
    m3 = m2 | (m2 >> 4);
    m4 = m3 | (m3 >> 8);
    m5 = m4 | (m4 >> 16);
    m6 = m5 | (m5 >> 32);
  end

  logic [63:0] masked;
  assign masked = draw & mask;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd       <= command;
      byte_reg  <= seed_byte;
      len       <= seed_length;
      range_reg <= draw_range;
    end
    if (ctl.shift_len) begin
      len <= len >> 8;
    end
    if (ctl.load_mask) begin
      mask <= m6;
    end

    if (rst || ctl.load_basis) begin
      hash[0] <= xsg_pkg::BASIS_W0;
      hash[1] <= xsg_pkg::BASIS_W1;
      hash[2] <= xsg_pkg::BASIS_W2;
      hash[3] <= xsg_pkg::BASIS_W3;
    end else if (ctl.mul_step) begin
      // ring: the finished word enters at the top, after four steps all are in place
      hash[0] <= hash[1];
      hash[1] <= hash[2];
      hash[2] <= hash[3];
      hash[3] <= acc[63:0];
    end
    if (ctl.mul_step) begin
      d1    <= mul_a;
      d2    <= d1;
      d3    <= d2;
      carry <= acc[73:64];
    end

    // generator words read as zero until seeded
    if (rst) begin
      gen[0] <= 64'd0;
      gen[1] <= 64'd0;
      gen[2] <= 64'd0;
      gen[3] <= 64'd0;
    end else if (ctl.load_gen) begin
      gen <= hash;
    end else if (ctl.gen_step) begin
      gen[0] <= s0n;
      gen[1] <= s1n;
      gen[2] <= s2n;
      gen[3] <= s3n;
      draw   <= gen_out;
    end

    if (ctl.clear_result) begin
      res_value  <= 64'd0;
      res_status <= 1'b0;
    end else if (ctl.set_zero_rng) begin
      res_value  <= 64'd0;
      res_status <= 1'b1;
    end else if (ctl.set_result) begin
      case (cmd)
        xsg_pkg::CMD_RAW:     res_value <= draw;
        xsg_pkg::CMD_UNIFORM: res_value <= draw >> xsg_pkg::UNIFORM_SHIFT;
        default:              res_value <= masked;
      endcase
    end

    if (ctl.load_out) begin
      value  <= res_value;
      status <= res_status;
    end
  end

  always_comb begin
    sts.cmd           = cmd;
    sts.len_zero      = (len == 32'd0);
    sts.len_next_zero = (len[31:8] == 24'd0);
    sts.range_zero    = (range_reg == 64'd0);
    sts.reject        = (masked >= range_reg);
  end

endmodule

### sv/xsg_ctrl.sv
// Controller: sequences seeding, warm-up, draws and rejection, and owns the handshakes.
`timescale 1ns / 1ps

module xsg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  xsg_pkg::sts_t       sts,
  output xsg_pkg::ctl_t       ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_WARM   = 3'd3;
  localparam logic [2:0] S_GEN    = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] cnt, cnt_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    ctl.mul_idx = cnt;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.clear_result = 1'b1;
        cnt_next         = 2'd0;
        unique case (sts.cmd) inside
          xsg_pkg::CMD_BEGIN: begin
            ctl.load_basis = 1'b1;
            state_next = sts.len_zero ? S_DONE : S_MUL;
          end
          xsg_pkg::CMD_BYTE: state_next = S_MUL;
          xsg_pkg::CMD_FINISH: begin
            ctl.load_gen = 1'b1;
            state_next   = S_WARM;
          end
          xsg_pkg::CMD_RAW, xsg_pkg::CMD_UNIFORM: state_next = S_GEN;
          xsg_pkg::CMD_BOUNDED: begin
            ctl.load_mask = 1'b1;
            if (sts.range_zero) begin
              ctl.clear_result = 1'b0;
              ctl.set_zero_rng = 1'b1;
              state_next       = S_DONE;
            end else begin
              state_next = S_GEN;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_MUL: begin
        ctl.mul_step = 1'b1;
        cnt_next     = cnt + 2'd1;
        if (cnt == 2'd3) begin
          if (sts.cmd == xsg_pkg::CMD_BEGIN) begin
            // keep absorbing while higher length bytes remain
            ctl.shift_len = 1'b1;
            state_next = sts.len_next_zero ? S_DONE : S_MUL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_WARM: begin
        ctl.gen_step = 1'b1;
        cnt_next     = cnt + 2'd1;
        if (cnt == 2'd3) begin
          state_next = S_DONE;
        end
      end
      S_GEN: begin
        ctl.gen_step = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        if (sts.cmd == xsg_pkg::CMD_BOUNDED && sts.reject) begin
          state_next = S_GEN;
        end else begin
          ctl.set_result = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    out_valid_next = out_valid;
    if (ctl.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
